/* src/bepf_pkg.sv */
// Package for the bridge egress port filter: sizes, field widths,
// domain bits and drop reason codes. No dependencies.
package bepf_pkg;

  // Multicast address table depth and filtered transport port limit.
  localparam int MCAST_TABLE_ENTRIES = 16;
  localparam int MAX_FILTER_PORTS    = 4;
  localparam int TBL_IDX_W = (MCAST_TABLE_ENTRIES > 1) ? $clog2(MCAST_TABLE_ENTRIES) : 1;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WLAN_BLOCK_MODE   = 3'd0,
    REG_FILTER_PORT_COUNT = 3'd1,
    REG_FILTER_PORT_A     = 3'd2,
    REG_FILTER_PORT_B     = 3'd3,
    REG_FILTER_PORT_C     = 3'd4,
    REG_FILTER_PORT_D     = 3'd5
  } cfg_reg_t;

  // Wireless blocking modes.
  typedef enum logic [1:0] {
    BLOCK_OFF    = 2'd0,
    BLOCK_WL_ANY = 2'd1,
    BLOCK_WL_LAN = 2'd2,
    BLOCK_WL_WAN = 2'd3
  } wlan_mode_t;

  // Domain mask bits.
  localparam int DOM_WAN_BIT  = 0;
  localparam int DOM_ELAN_BIT = 1;
  localparam int DOM_WLAN_BIT = 2;

  localparam logic [12:0] FRAG_OFFSET_MASK = 13'h1fff;

  // Drop reason codes.
  typedef enum logic [2:0] {
    REASON_NONE     = 3'd0,
    REASON_PORT     = 3'd1,
    REASON_DOMAIN   = 3'd2,
    REASON_WLAN     = 3'd3,
    REASON_MCAST    = 3'd4
  } reason_t;

  // One query item.
  typedef struct packed {
    logic [15:0] ip_frag_word;
    logic [15:0] l4_dest_port;
    logic [23:0] dest_mac_low;
    logic        dest_ipv4_mcast;
    logic        egress_is_radio;
    logic [2:0]  egress_domains;
    logic [2:0]  ingress_domains;
    logic        egress_forwarding;
    logic [3:0]  egress_port;
    logic [3:0]  ingress_port;
  } query_t;

endpackage

/* src/bridge_egress_port_filter.sv */
// Top level of the bridge egress port filter: input register, decision
// logic, multicast address table and result register. Uses bepf_pkg.

// Each accepted query gives one deliver/drop result. The block takes one
// query per clock cycle while the output side takes its results. Each
// query passes through the input register, where the port, domain,
// wireless and multicast checks and the table lookup run, and then the
// result register. A table entry learned by one query is seen by the
// query right behind it. The table has MCAST_TABLE_ENTRIES entries with
// valid bits that reset clears at once, so there is no clearing pass.
// Configuration writes take effect at the next clock edge.
module bridge_egress_port_filter
  import bepf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Query stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // Fields from bit 0: ingress_port[3:0], egress_port[7:4],
  // egress_forwarding[8], ingress_domains[11:9], egress_domains[14:12],
  // egress_is_radio[15], dest_ipv4_mcast[16], dest_mac_low[40:17],
  // l4_dest_port[56:41], ip_frag_word[72:57], zero pad [79:73].
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // Result stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // Fields from bit 0: deliver[0], drop_reason[3:1], zero pad [7:4].
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // Configuration registers.
  logic [1:0]  wlan_block_mode;
  logic [2:0]  filter_port_count;
  logic [15:0] filter_ports [4];

  // Pipeline registers.
  logic        in_valid;
  query_t      in_q;
  logic        out_valid;
  logic        out_deliver;
  reason_t     out_reason;

  // Multicast address table.
  logic        tbl_valid [MCAST_TABLE_ENTRIES];
  logic [23:0] tbl_addr  [MCAST_TABLE_ENTRIES];

  // Decision signals.
  logic                 advance;
  reason_t              reason_next;
  logic                 learn;
  logic [TBL_IDX_W-1:0] tbl_idx;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      wlan_block_mode   <= BLOCK_OFF;
      filter_port_count <= 3'd0;
      for (int i = 0; i < 4; i++) begin
        filter_ports[i] <= 16'd0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_WLAN_BLOCK_MODE:   wlan_block_mode   <= cfg_wdata[1:0];
        REG_FILTER_PORT_COUNT: filter_port_count <= cfg_wdata[2:0];
        REG_FILTER_PORT_A:     filter_ports[0]   <= cfg_wdata[15:0];
        REG_FILTER_PORT_B:     filter_ports[1]   <= cfg_wdata[15:0];
        REG_FILTER_PORT_C:     filter_ports[2]   <= cfg_wdata[15:0];
        REG_FILTER_PORT_D:     filter_ports[3]   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_q <= query_t'(s_tdata[$bits(query_t)-1:0]);
    end
  end

  // Decision logic on the registered query.
  always_comb begin
    logic [2:0]  any_dom;
    logic [2:0]  n_ports;
    logic        port_hit;
    logic [7:0]  hash;
    logic        wlan_block;
    any_dom    = in_q.ingress_domains | in_q.egress_domains;
    port_hit   = 1'b0;
    learn      = 1'b0;

    // Effective number of filtered ports.
    n_ports = filter_port_count;
    if (n_ports > 3'(MAX_FILTER_PORTS)) begin
      n_ports = 3'(MAX_FILTER_PORTS);
    end
    if (n_ports > 3'd4) begin
      n_ports = 3'd4;
    end

    // Non-first fragments never match a filtered port.
    if ((in_q.ip_frag_word[12:0] & FRAG_OFFSET_MASK) == 13'd0) begin
      for (int i = 0; i < 4; i++) begin
        if ((3'(i) < n_ports) && (in_q.l4_dest_port == filter_ports[i])) begin
          port_hit = 1'b1;
        end
      end
    end

    // Table slot from the XOR of the three low MAC bytes.
    hash = (in_q.dest_mac_low[23:16] ^ in_q.dest_mac_low[15:8] ^ in_q.dest_mac_low[7:0])
           & 8'(MCAST_TABLE_ENTRIES - 1);
    if (9'(hash) >= 9'(MCAST_TABLE_ENTRIES)) begin
      hash = 8'd0;
    end
    tbl_idx = TBL_IDX_W'(hash);

    // Wireless blocking by mode.
    unique case (wlan_block_mode)
      BLOCK_WL_ANY: wlan_block = any_dom[DOM_WLAN_BIT];
      BLOCK_WL_LAN: wlan_block = any_dom[DOM_WLAN_BIT] && any_dom[DOM_ELAN_BIT];
      BLOCK_WL_WAN: wlan_block = any_dom[DOM_WLAN_BIT] && any_dom[DOM_WAN_BIT];
      default:      wlan_block = 1'b0;
    endcase

    // Checks in priority order; the first failing one sets the reason.
    if ((in_q.ingress_port == in_q.egress_port) || !in_q.egress_forwarding) begin
      reason_next = REASON_PORT;
    end else if ((in_q.ingress_domains[DOM_WAN_BIT] && in_q.egress_domains[DOM_WAN_BIT]) ||
                 (in_q.ingress_domains[DOM_ELAN_BIT] && in_q.egress_domains[DOM_ELAN_BIT]))
    begin
      reason_next = REASON_DOMAIN;
    end else if (wlan_block) begin
      reason_next = REASON_WLAN;
    end else if ((filter_port_count == 3'd0) || !in_q.dest_ipv4_mcast ||
                 !in_q.egress_is_radio) begin
      reason_next = REASON_NONE;
    end else if (port_hit) begin
      // A filtered flow is learned only into a free slot.
      learn       = !tbl_valid[tbl_idx];
      reason_next = REASON_MCAST;
    end else if (tbl_valid[tbl_idx] && (tbl_addr[tbl_idx] == in_q.dest_mac_low)) begin
      reason_next = REASON_MCAST;
    end else begin
      reason_next = REASON_NONE;
    end
  end

  // Table update as the query moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MCAST_TABLE_ENTRIES; i++) begin
        tbl_valid[i] <= 1'b0;
      end
    end else if (advance && learn) begin
      tbl_valid[tbl_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && learn) begin
      tbl_addr[tbl_idx] <= in_q.dest_mac_low;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_deliver <= (reason_next == REASON_NONE);
      out_reason  <= reason_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_reason, out_deliver};

endmodule

/* src/bepf_checker.sv */
// Port-level checker for the bridge egress port filter, bound to the top
// level. Uses bepf_pkg.
module bepf_checker
  import bepf_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A delivered frame carries no drop reason.
  a_deliver_no_reason: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[3:1] == REASON_NONE))
    else $error("deliver with nonzero drop reason");

  // A dropped frame always names a defined reason.
  a_drop_has_reason: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |->
      (m_tdata[3:1] == REASON_PORT || m_tdata[3:1] == REASON_DOMAIN ||
       m_tdata[3:1] == REASON_WLAN || m_tdata[3:1] == REASON_MCAST))
    else $error("drop without a valid reason");

  // With no result pending the block can always take a query.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind bridge_egress_port_filter bepf_checker u_bepf_checker (.*);

/* test/bridge_egress_port_filter_tb.sv */
`timescale 1ns / 1ps
// Testbench for bridge_egress_port_filter: directed and random egress queries,
// each result checked against an in-bench model of the egress decision and of
// the multicast address table. Depends on bepf_pkg and the block's RTL.
module bridge_egress_port_filter_tb;
  import bepf_pkg::*;

  // One expected result of a query.
  typedef struct packed {
    logic    deliver;
    reason_t reason;
  } verdict_t;

  // Domain masks and the two register indexes the block does not decode.
  localparam logic [2:0] DOM_WAN  = 3'(1 << DOM_WAN_BIT);
  localparam logic [2:0] DOM_ELAN = 3'(1 << DOM_ELAN_BIT);
  localparam logic [2:0] DOM_WLAN = 3'(1 << DOM_WLAN_BIT);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int POOL_SIZE = 32;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Model copy of the configuration and of the multicast address table.
  wlan_mode_t  mdl_mode;
  logic [2:0]  mdl_port_count;
  logic [15:0] mdl_ports [4];
  logic        mdl_valid [MCAST_TABLE_ENTRIES];
  logic [23:0] mdl_addr  [MCAST_TABLE_ENTRIES];

  verdict_t    pending_verdicts [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [23:0] mac_pool [POOL_SIZE];

  bridge_egress_port_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // Egress decision for one query; learns into the model table as a side effect.
  function automatic reason_t egress_verdict(query_t q);
    logic [2:0] any_dom;
    logic [TBL_IDX_W-1:0] slot;
    logic hit;
    int n;
    any_dom = q.ingress_domains | q.egress_domains;
    hit = 1'b0;
    if (q.ingress_port == q.egress_port || !q.egress_forwarding) return REASON_PORT;
    if ((q.ingress_domains & q.egress_domains & (DOM_WAN | DOM_ELAN)) != 3'd0)
      return REASON_DOMAIN;
    case (mdl_mode)
      BLOCK_WL_ANY: if (any_dom[DOM_WLAN_BIT]) return REASON_WLAN;
      BLOCK_WL_LAN: if (any_dom[DOM_WLAN_BIT] && any_dom[DOM_ELAN_BIT]) return REASON_WLAN;
      BLOCK_WL_WAN: if (any_dom[DOM_WLAN_BIT] && any_dom[DOM_WAN_BIT]) return REASON_WLAN;
      default: ;
    endcase
    if (mdl_port_count == 3'd0 || !q.dest_ipv4_mcast || !q.egress_is_radio)
      return REASON_NONE;
    // Counts above the limit use every filtered port.
    n = (mdl_port_count > MAX_FILTER_PORTS) ? MAX_FILTER_PORTS : int'(mdl_port_count);
    // Only a first fragment carries a transport port worth matching.
    if ((q.ip_frag_word[12:0] & FRAG_OFFSET_MASK) == 13'd0)
      for (int i = 0; i < n; i++)
        if (q.l4_dest_port == mdl_ports[i]) hit = 1'b1;
    slot = TBL_IDX_W'(q.dest_mac_low[23:16] ^ q.dest_mac_low[15:8] ^ q.dest_mac_low[7:0]);
    if (hit) begin
      // An occupied slot keeps its first address.
      if (!mdl_valid[slot]) begin
        mdl_valid[slot] = 1'b1;
        mdl_addr[slot] = q.dest_mac_low;
      end
      return REASON_MCAST;
    end
    if (mdl_valid[slot] && mdl_addr[slot] == q.dest_mac_low) return REASON_MCAST;
    return REASON_NONE;
  endfunction

  // Predict the result of every query transfer.
  always @(posedge clk) begin
    reason_t r;
    if (!rst && s_tvalid && s_tready) begin
      r = egress_verdict(query_t'(s_tdata[$bits(query_t)-1:0]));
      pending_verdicts.push_back('{deliver: (r == REASON_NONE), reason: r});
    end
  end

  // Compare every result transfer with the oldest pending verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer at %0t: tdata=%h", $realtime, m_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tdata[0] !== want.deliver || m_tdata[3:1] !== want.reason ||
            m_tdata[7:4] !== 4'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected deliver=%0d reason=%0d,",
                     $realtime, want.deliver, want.reason,
                     " got deliver=%0d reason=%0d pad=%h",
                     m_tdata[0], m_tdata[3:1], m_tdata[7:4]);
        end
      end
    end
  end

  // Result side stalls at random.
  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  function automatic query_t mk_query(logic [3:0] ip, logic [3:0] ep, logic fwd,
                                      logic [2:0] idom, logic [2:0] edom, logic radio,
                                      logic mcast, logic [23:0] mac, logic [15:0] l4,
                                      logic [15:0] frag);
    query_t q;
    q.ingress_port = ip;
    q.egress_port = ep;
    q.egress_forwarding = fwd;
    q.ingress_domains = idom;
    q.egress_domains = edom;
    q.egress_is_radio = radio;
    q.dest_ipv4_mcast = mcast;
    q.dest_mac_low = mac;
    q.l4_dest_port = l4;
    q.ip_frag_word = frag;
    return q;
  endfunction

  // Random query; most are steered past the early checks into the multicast filter.
  function automatic query_t rand_query();
    logic [95:0] raw;
    query_t q;
    raw = {$urandom, $urandom, $urandom};
    q = raw[$bits(query_t)-1:0];
    if ($urandom_range(0, 99) < 75) begin
      if (q.ingress_port == q.egress_port) q.egress_port = ~q.ingress_port;
      q.egress_forwarding = 1'b1;
      q.egress_domains[1:0] = q.egress_domains[1:0] & ~q.ingress_domains[1:0];
      if (mdl_mode != BLOCK_OFF && $urandom_range(0, 3) != 0) begin
        q.ingress_domains[DOM_WLAN_BIT] = 1'b0;
        q.egress_domains[DOM_WLAN_BIT] = 1'b0;
      end
      q.dest_ipv4_mcast = ($urandom_range(0, 9) != 0);
      q.egress_is_radio = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 3) != 0) q.dest_mac_low = mac_pool[$urandom_range(0, POOL_SIZE-1)];
      if ($urandom_range(0, 9) < 6) q.l4_dest_port = mdl_ports[$urandom_range(0, 3)];
      if ($urandom_range(0, 9) < 7) q.ip_frag_word[12:0] = 13'd0;
    end
    return q;
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // One register write; the model follows once the write edge has passed.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WLAN_BLOCK_MODE:   mdl_mode = wlan_mode_t'(val[1:0]);
      REG_FILTER_PORT_COUNT: mdl_port_count = val[2:0];
      REG_FILTER_PORT_A:     mdl_ports[0] = val;
      REG_FILTER_PORT_B:     mdl_ports[1] = val;
      REG_FILTER_PORT_C:     mdl_ports[2] = val;
      REG_FILTER_PORT_D:     mdl_ports[3] = val;
      default: ;
    endcase
  endtask

  // Full setting; unused upper data bits carry random junk.
  task automatic configure(wlan_mode_t mode, logic [2:0] count,
                           logic [15:0] pa, logic [15:0] pb, logic [15:0] pc,
                           logic [15:0] pd);
    write_reg(REG_WLAN_BLOCK_MODE, {14'($urandom), mode});
    write_reg(REG_FILTER_PORT_COUNT, {13'($urandom), count});
    write_reg(REG_FILTER_PORT_A, pa);
    write_reg(REG_FILTER_PORT_B, pb);
    write_reg(REG_FILTER_PORT_C, pc);
    write_reg(REG_FILTER_PORT_D, pd);
  endtask

  // Offer one query and hold it until its transfer.
  task automatic send_query(query_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_TDATA_W-$bits(query_t)){1'b0}}, q};
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // Stop sending and let every pending result arrive.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // Port, forwarding and domain checks under the reset configuration.
  task automatic test_port_and_domain();
    send_query(mk_query(4'd3, 4'd3, 1'b1, 3'd0, 3'd0, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0));
    send_query(mk_query(4'd2, 4'd5, 1'b0, 3'd0, 3'd0, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0));
    send_query(mk_query(4'd0, 4'd15, 1'b1, DOM_WAN, DOM_WAN, 1'b0, 1'b0, 24'h0, 16'h0,
                        16'h0));
    send_query(mk_query(4'd15, 4'd0, 1'b1, DOM_ELAN | DOM_WLAN, DOM_ELAN, 1'b1, 1'b1,
                        24'hffffff, 16'hffff, 16'hffff));
    // Port check wins over domain isolation.
    send_query(mk_query(4'd4, 4'd4, 1'b0, DOM_WAN, DOM_WAN, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0));
    // Filter is off after reset.
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_WAN, DOM_ELAN | DOM_WLAN, 1'b1, 1'b1,
                        24'h123456, 16'h0, 16'h0));
  endtask

  // Each wireless blocking mode, and domain isolation ahead of it.
  task automatic test_wlan_block();
    wait_idle();
    write_reg(REG_WLAN_BLOCK_MODE, CFG_DATA_W'(BLOCK_WL_ANY));
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_WLAN, 3'd0, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0));
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_WAN | DOM_WLAN, DOM_WAN, 1'b0, 1'b0, 24'h0,
                        16'h0, 16'h0));
    wait_idle();
    write_reg(REG_WLAN_BLOCK_MODE, CFG_DATA_W'(BLOCK_WL_LAN));
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_WLAN, DOM_ELAN, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0));
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_WLAN, DOM_WAN, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0));
    wait_idle();
    write_reg(REG_WLAN_BLOCK_MODE, CFG_DATA_W'(BLOCK_WL_WAN));
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_WAN, DOM_WLAN, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0));
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_ELAN, DOM_WLAN, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0));
  endtask

  // Learning, collisions, fragments, non-radio egress, counts and unused indexes.
  task automatic test_mcast_filter();
    logic [23:0] mac_a, mac_b, mac_c, mac_z;
    mac_a = 24'h123456;
    mac_b = mac_a ^ 24'h010100;   // same table slot as mac_a
    mac_c = 24'hffffff;
    mac_z = 24'h000000;
    wait_idle();
    configure(BLOCK_OFF, 3'd7, 16'h0000, 16'hffff, 16'd5353, 16'd1900);
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_ELAN, DOM_WLAN, 1'b1, 1'b1, mac_a, 16'hffff,
                        16'h0));
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_ELAN, DOM_WLAN, 1'b1, 1'b1, mac_a, 16'd80,
                        16'h0));
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_ELAN, DOM_WLAN, 1'b1, 1'b1, mac_b, 16'h0000,
                        16'h0));
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_ELAN, DOM_WLAN, 1'b1, 1'b1, mac_b, 16'd80,
                        16'h0));
    // A non-first fragment never matches a port; flag bits alone do not matter.
    send_query(mk_query(4'd5, 4'd9, 1'b1, 3'd0, 3'd0, 1'b1, 1'b1, mac_c, 16'd1900, 16'h0001));
    send_query(mk_query(4'd5, 4'd9, 1'b1, 3'd0, 3'd0, 1'b1, 1'b1, mac_c, 16'd1900, 16'he000));
    // Non-radio egress leaves the table alone.
    send_query(mk_query(4'd5, 4'd9, 1'b1, 3'd0, 3'd0, 1'b0, 1'b1, mac_z, 16'd5353, 16'h0));
    send_query(mk_query(4'd5, 4'd9, 1'b1, 3'd0, 3'd0, 1'b1, 1'b1, mac_z, 16'd80, 16'h0));
    send_query(mk_query(4'd5, 4'd9, 1'b1, 3'd0, 3'd0, 1'b1, 1'b0, mac_z, 16'd5353, 16'h0));
    // The learned address still drops a later fragment.
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_ELAN, DOM_WLAN, 1'b1, 1'b1, mac_a, 16'd80,
                        16'h1fff));
    wait_idle();
    write_reg(REG_FILTER_PORT_COUNT, 16'd1);
    send_query(mk_query(4'd5, 4'd9, 1'b1, 3'd0, 3'd0, 1'b1, 1'b1, mac_z, 16'hffff, 16'h0));
    // Writes to undecoded indexes must change nothing.
    wait_idle();
    write_reg(REG_UNUSED_LO, 16'hffff);
    write_reg(REG_UNUSED_HI, 16'h0000);
    send_query(mk_query(4'd5, 4'd9, 1'b1, 3'd0, 3'd0, 1'b1, 1'b1, mac_z, 16'h0000, 16'h0));
    wait_idle();
    write_reg(REG_FILTER_PORT_COUNT, 16'd0);
    send_query(mk_query(4'd1, 4'd2, 1'b1, DOM_ELAN, DOM_WLAN, 1'b1, 1'b1, mac_a, 16'd80,
                        16'h0));
  endtask

  // Random queries under three fresh settings with the given idle rates.
  task automatic test_random(int unsigned send_pct, int unsigned recv_pct, int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < 3; s++) begin
      wait_idle();
      configure(wlan_mode_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                pick_port(), pick_port(), pick_port(), pick_port());
      repeat (count / 3) send_query(rand_query());
    end
  endtask

  initial begin
    // Model state after reset.
    mdl_mode = BLOCK_OFF;
    mdl_port_count = 3'd0;
    for (int i = 0; i < 4; i++) mdl_ports[i] = 16'h0;
    for (int i = 0; i < MCAST_TABLE_ENTRIES; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_addr[i] = 24'h0;
    end
    // Address pool in colliding pairs so occupied slots come up often.
    for (int i = 0; i < POOL_SIZE / 2; i++) begin
      mac_pool[i] = 24'($urandom);
      mac_pool[i + POOL_SIZE / 2] = mac_pool[i] ^ 24'h010100;
    end
    send_idle_pct = 28;
    recv_idle_pct = 63;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_port_and_domain();
    test_wlan_block();
    test_mcast_filter();
    test_random(28, 63, 450);
    test_random(63, 28, 450);
    test_random(0, 0, 450);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
src/bepf_pkg.sv
src/bridge_egress_port_filter.sv
src/bepf_checker.sv
test/bridge_egress_port_filter_tb.sv
